// File: hw/rtl/hafu_pkg.sv
// Package with the shared types and constants of the hysteresis alert flasher.
`timescale 1ns / 1ps

package hafu_pkg;

    localparam int unsigned LevelWidth = 32;
    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned HalfWidth  = 16;
    localparam int unsigned ColorWidth = 24;
    localparam int unsigned AluWidth   = LevelWidth + 1;
    localparam int unsigned IndexWidth = 3;
    localparam int unsigned DataWidth  = 32;
    localparam int unsigned CountWidth = $clog2(TimeWidth);

    localparam logic [IndexWidth-1:0] RegEnabled       = 3'd0;
    localparam logic [IndexWidth-1:0] RegTripLevel     = 3'd1;
    localparam logic [IndexWidth-1:0] RegReleaseLevel  = 3'd2;
    localparam logic [IndexWidth-1:0] RegHalfPeriodMs  = 3'd3;
    localparam logic [IndexWidth-1:0] RegAlertColor    = 3'd4;
    localparam logic [IndexWidth-1:0] RegNoSignalColor = 3'd5;

    typedef struct packed {
        logic                         enabled;
        logic signed [LevelWidth-1:0] trip_level;
        logic signed [LevelWidth-1:0] release_level;
        logic [HalfWidth-1:0]         half_period_ms;
        logic [ColorWidth-1:0]        alert_color;
        logic [ColorWidth-1:0]        no_signal_color;
    } t_cfg;

    typedef struct packed {
        logic [AluWidth-1:0] a;
        logic [AluWidth-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [AluWidth-1:0] diff;
        logic                lt;
    } t_alu_rsp;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLAMP = 6'b000010,
        S_TRIP  = 6'b000100,
        S_REL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

// File: hw/rtl/hafu_alu.sv
// Shared subtractor that serves every compare and every divider step.
`timescale 1ns / 1ps

module hafu_alu (
    input  hafu_pkg::t_alu_req i_req,
    output hafu_pkg::t_alu_rsp o_rsp
);

    logic [hafu_pkg::AluWidth-1:0] diff;

    assign diff       = i_req.a - i_req.b;
    assign o_rsp.diff = diff;
    assign o_rsp.lt   = diff[hafu_pkg::AluWidth-1];

endmodule

// File: hw/rtl/hafu_core.sv
// Sequencer that holds the alert latch and drives the shared subtractor.
`timescale 1ns / 1ps

module hafu_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hafu_pkg::t_cfg                      i_cfg,
    input  logic                                i_start,
    input  logic signed [hafu_pkg::LevelWidth-1:0] i_value,
    input  logic                                i_valid,
    input  logic [hafu_pkg::TimeWidth-1:0]      i_now,
    output logic                                o_idle,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [hafu_pkg::ColorWidth-1:0]     o_color,
    output logic                                o_latched
);

    hafu_pkg::t_state                     r_state, n_state;
    logic                                 r_active, n_active;
    logic signed [hafu_pkg::LevelWidth-1:0] r_value, n_value;
    logic signed [hafu_pkg::LevelWidth-1:0] r_rel, n_rel;
    logic                                 r_ge, n_ge;
    logic [hafu_pkg::TimeWidth-1:0]       r_now, n_now;
    logic [hafu_pkg::HalfWidth-1:0]       r_rem, n_rem;
    logic [hafu_pkg::CountWidth-1:0]      r_cnt, n_cnt;
    logic [hafu_pkg::ColorWidth-1:0]      r_color, n_color;
    hafu_pkg::t_alu_req                   alu_req;
    hafu_pkg::t_alu_rsp                   alu_rsp;
    logic                                 latch_next;

    hafu_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    always_comb begin
        alu_req = '0;
        case (r_state)
            hafu_pkg::S_CLAMP: begin
                alu_req.a = {i_cfg.trip_level[hafu_pkg::LevelWidth-1], i_cfg.trip_level};
                alu_req.b = {i_cfg.release_level[hafu_pkg::LevelWidth-1],
                             i_cfg.release_level};
            end
            hafu_pkg::S_TRIP: begin
                alu_req.a = {r_value[hafu_pkg::LevelWidth-1], r_value};
                alu_req.b = {i_cfg.trip_level[hafu_pkg::LevelWidth-1], i_cfg.trip_level};
            end
            hafu_pkg::S_REL: begin
                alu_req.a = {r_value[hafu_pkg::LevelWidth-1], r_value};
                alu_req.b = {r_rel[hafu_pkg::LevelWidth-1], r_rel};
            end
            hafu_pkg::S_DIV: begin
                alu_req.a = {{(hafu_pkg::AluWidth-hafu_pkg::HalfWidth-1){1'b0}},
                             r_rem, r_now[hafu_pkg::TimeWidth-1]};
                alu_req.b = {{(hafu_pkg::AluWidth-hafu_pkg::HalfWidth){1'b0}},
                             i_cfg.half_period_ms};
            end
            default: alu_req = '0;
        endcase
    end

    assign latch_next = r_active ? !alu_rsp.lt : r_ge;

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_value  = r_value;
        n_rel    = r_rel;
        n_ge     = r_ge;
        n_now    = r_now;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_color  = r_color;
        case (r_state)
            hafu_pkg::S_IDLE: begin
                if (i_start) begin
                    n_value = i_value;
                    n_now   = i_now;
                    if (!i_cfg.enabled) begin
                        n_active = 1'b0;
                        n_color  = '0;
                        n_state  = hafu_pkg::S_DONE;
                    end else if (!i_valid) begin
                        n_active = 1'b0;
                        n_color  = i_cfg.no_signal_color;
                        n_state  = hafu_pkg::S_DONE;
                    end else begin
                        n_state = hafu_pkg::S_CLAMP;
                    end
                end
            end
            hafu_pkg::S_CLAMP: begin
                n_rel   = alu_rsp.lt ? i_cfg.trip_level : i_cfg.release_level;
                n_state = hafu_pkg::S_TRIP;
            end
            hafu_pkg::S_TRIP: begin
                n_ge    = !alu_rsp.lt;
                n_state = hafu_pkg::S_REL;
            end
            hafu_pkg::S_REL: begin
                n_active = latch_next;
                n_rem    = '0;
                n_cnt    = hafu_pkg::CountWidth'(hafu_pkg::TimeWidth - 1);
                if (!latch_next) begin
                    n_color = '0;
                    n_state = hafu_pkg::S_DONE;
                end else if (i_cfg.half_period_ms == '0) begin
                    n_color = i_cfg.alert_color;
                    n_state = hafu_pkg::S_DONE;
                end else begin
                    n_state = hafu_pkg::S_DIV;
                end
            end
            hafu_pkg::S_DIV: begin
                n_rem = alu_rsp.lt ? {r_rem[hafu_pkg::HalfWidth-2:0],
                                      r_now[hafu_pkg::TimeWidth-1]}
                                   : alu_rsp.diff[hafu_pkg::HalfWidth-1:0];
                n_now = {r_now[hafu_pkg::TimeWidth-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_color = alu_rsp.lt ? i_cfg.alert_color : '0;
                    n_state = hafu_pkg::S_DONE;
                end
            end
            hafu_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = hafu_pkg::S_IDLE;
                end
            end
            default: n_state = hafu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hafu_pkg::S_IDLE;
            r_active <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
        end
        r_value <= n_value;
        r_rel   <= n_rel;
        r_ge    <= n_ge;
        r_now   <= n_now;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_color <= n_color;
    end

    assign o_idle      = (r_state == hafu_pkg::S_IDLE);
    assign o_res_valid = (r_state == hafu_pkg::S_DONE);
    assign o_color     = r_color;
    assign o_latched   = r_active;

endmodule

// File: hw/rtl/hysteresis_alert_flasher_unit.sv
// Top level of the hysteresis alert flasher with registers and output stage.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// input     slave      i_s_tvalid / o_s_tready     i_s_tdata, i_s_tuser
// result    master     o_m_tvalid / i_m_tready     o_m_tdata
// config    slave      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// When enabled, valid and latched with a non-zero half period, an item runs the
// one-bit-per-cycle division of the timestamp on the shared subtractor. Reset
// is synchronous and clears the latch, state, config and output valid flag. A
// result waits in the output register while the next item is taken; a stalled
// result holds the sequencer once it has finished.

module hysteresis_alert_flasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] sample_value, [63:32] now_ms
    input  logic        i_s_tuser,   // [0] sample_valid
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [23:0] pixel_color, [24] alert_latched, rest zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [hafu_pkg::IndexWidth-1:0] i_cfg_index,
    input  logic [hafu_pkg::DataWidth-1:0]  i_cfg_data
);

    hafu_pkg::t_cfg                     r_cfg;
    logic                               r_out_valid;
    logic [hafu_pkg::ColorWidth-1:0]    r_out_color;
    logic                               r_out_latched;
    logic                               core_idle;
    logic                               core_res_valid;
    logic                               res_ready;
    logic [hafu_pkg::ColorWidth-1:0]    core_color;
    logic                               core_latched;
    logic                               in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = core_idle;
    assign in_accept   = i_s_tvalid && core_idle;
    assign res_ready   = !r_out_valid || i_m_tready;

    hafu_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (in_accept),
        .i_value     (i_s_tdata[31:0]),
        .i_valid     (i_s_tuser),
        .i_now       (i_s_tdata[63:32]),
        .o_idle      (core_idle),
        .o_res_valid (core_res_valid),
        .i_res_ready (res_ready),
        .o_color     (core_color),
        .o_latched   (core_latched)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hafu_pkg::RegEnabled:       r_cfg.enabled         <= i_cfg_data[0];
                hafu_pkg::RegTripLevel:     r_cfg.trip_level      <= i_cfg_data;
                hafu_pkg::RegReleaseLevel:  r_cfg.release_level   <= i_cfg_data;
                hafu_pkg::RegHalfPeriodMs:
                    r_cfg.half_period_ms <= i_cfg_data[hafu_pkg::HalfWidth-1:0];
                hafu_pkg::RegAlertColor:
                    r_cfg.alert_color <= i_cfg_data[hafu_pkg::ColorWidth-1:0];
                hafu_pkg::RegNoSignalColor:
                    r_cfg.no_signal_color <= i_cfg_data[hafu_pkg::ColorWidth-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (core_res_valid && res_ready) begin
            r_out_color   <= core_color;
            r_out_latched <= core_latched;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_latched, r_out_color};

endmodule
